// ===== sv/page_table_walker_top_assert.svh =====
// Assertion macros for the page table walker.
// Included by page_table_walker_top; depends on nothing else.
`ifndef PAGE_TABLE_WALKER_TOP_ASSERT_SVH
`define PAGE_TABLE_WALKER_TOP_ASSERT_SVH

`ifndef SYNTH
`define PTW_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define PTW_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`define PTW_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define PTW_ASSERT(lbl, clk, rstn, prop, msg)
`define PTW_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define PTW_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== sv/ptw_pkg.sv =====
// Shared types and constants of the page table walker.
// Used by ptw_walk and page_table_walker_top; depends on nothing.
`default_nettype none

package ptw_pkg;

  localparam int PTW_TABLE_COUNT   = 16;
  localparam int ENTRIES_PER_TABLE = 512;
  localparam int IDX_W             = 9;
  localparam int FRAME_W           = 40;
  localparam int VA_W              = 48;
  localparam int PA_W              = 52;
  localparam int SLOT_W            = 13;
  localparam int ENTRY_W           = 64;
  localparam int PRESENT_BIT       = 0;
  localparam int SIZE_BIT          = 7;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_XLATE = 1'b1;

  localparam logic REG_ROOT_FRAME  = 1'b0;
  localparam logic REG_WINDOW_BASE = 1'b1;

  localparam logic [1:0] LEAF_NONE = 2'd0;
  localparam logic [1:0] LEAF_4K   = 2'd1;
  localparam logic [1:0] LEAF_2M   = 2'd2;
  localparam logic [1:0] LEAF_1G   = 2'd3;

  typedef struct packed {
    logic            mapped;
    logic [PA_W-1:0] physical_address;
    logic [1:0]      leaf_level;
    logic            window_fault;
  } ptw_res_t;

endpackage

`default_nettype wire

// ===== sv/ptw_mem.sv =====
// Table memory: one write port and one registered read port.
// Stand-alone; instantiated by page_table_walker_top.
`default_nettype none

module ptw_mem #(
  parameter int Depth = 8192,
  parameter int AddrW = 13,
  parameter int DataW = 64
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== sv/ptw_walk.sv =====
// Walk sequencer: takes items, writes entries and steps through the four table levels.
// Depends on ptw_pkg; drives the ports of ptw_mem.
`default_nettype none

module ptw_walk import ptw_pkg::*; #(
  parameter int TableCount = PTW_TABLE_COUNT,
  localparam int TblW = $clog2(TableCount),
  localparam int AddrW = TblW + IDX_W
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                func_i,
  input  logic [VA_W-1:0]     virtual_address_i,
  input  logic [SLOT_W-1:0]   entry_slot_i,
  input  logic [ENTRY_W-1:0]  entry_word_i,
  input  logic [FRAME_W-1:0]  root_frame_i,
  input  logic [FRAME_W-1:0]  win_base_i,
  output logic                mem_we_o,
  output logic [AddrW-1:0]    mem_waddr_o,
  output logic [ENTRY_W-1:0]  mem_wdata_o,
  output logic                mem_re_o,
  output logic [AddrW-1:0]    mem_raddr_o,
  input  logic [ENTRY_W-1:0]  mem_rdata_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output ptw_res_t            res_o
);

  localparam int MemDepth = TableCount * ENTRIES_PER_TABLE;

  localparam logic [1:0] LVL_ROOT = 2'd0;
  localparam logic [1:0] LVL_PDPT = 2'd1;
  localparam logic [1:0] LVL_PD   = 2'd2;
  localparam logic [1:0] LVL_PT   = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_OUT
  } state_e;

  state_e            state_q;
  logic [VA_W-1:0]   va_q;
  logic [1:0]        lvl_q;
  ptw_res_t          res_q;

  logic              accept;
  logic              xlate;
  logic              slot_ok;
  logic [FRAME_W-1:0] frame_sel;
  logic [IDX_W-1:0]  idx_sel;
  logic [FRAME_W-1:0] diff;
  logic              in_win;
  logic              present;
  logic              leaf_1g;
  logic              leaf_2m;
  logic              leaf_4k;
  logic              descend;

  function automatic logic [IDX_W-1:0] va_index(input logic [VA_W-1:0] va,
                                                 input logic [1:0] lvl);
    logic [IDX_W-1:0] idx;
    unique case (lvl)
      LVL_ROOT: idx = va[47:39];
      LVL_PDPT: idx = va[38:30];
      LVL_PD:   idx = va[29:21];
      default:  idx = va[20:12];
    endcase
    return idx;
  endfunction

  always_comb begin
    accept    = in_valid_i && (state_q == S_IDLE);
    xlate     = accept && (func_i == FUNC_XLATE);
    slot_ok   = 32'(entry_slot_i) < 32'(MemDepth);
    frame_sel = (state_q == S_IDLE) ? root_frame_i : mem_rdata_i[51:12];
    idx_sel   = (state_q == S_IDLE) ? virtual_address_i[47:39]
                                    : va_index(va_q, lvl_q + 2'd1);
    diff      = frame_sel - win_base_i;
    in_win    = (frame_sel >= win_base_i) && (diff < FRAME_W'(TableCount));
    present   = mem_rdata_i[PRESENT_BIT];
    leaf_1g   = (lvl_q == LVL_PDPT) && mem_rdata_i[SIZE_BIT];
    leaf_2m   = (lvl_q == LVL_PD) && mem_rdata_i[SIZE_BIT];
    leaf_4k   = (lvl_q == LVL_PT);
    descend   = (state_q == S_CHECK) && present && !leaf_1g && !leaf_2m && !leaf_4k
                && in_win;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign mem_we_o    = accept && (func_i == FUNC_WRITE) && slot_ok;
  assign mem_waddr_o = AddrW'(entry_slot_i);
  assign mem_wdata_o = entry_word_i;
  assign mem_re_o    = (xlate && in_win) || descend;
  assign mem_raddr_o = {diff[TblW-1:0], idx_sel};
  assign res_valid_o = (state_q == S_OUT);
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      va_q    <= '0;
      lvl_q   <= LVL_ROOT;
      res_q   <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (xlate) begin
            va_q  <= virtual_address_i;
            lvl_q <= LVL_ROOT;
            if (in_win) begin
              state_q <= S_CHECK;
            end else begin
              res_q   <= '{mapped: 1'b0, physical_address: '0,
                           leaf_level: LEAF_NONE, window_fault: 1'b1};
              state_q <= S_OUT;
            end
          end
        end
        S_CHECK: begin
          priority if (!present) begin
            res_q   <= '0;
            state_q <= S_OUT;
          end else if (leaf_1g) begin
            res_q   <= '{mapped: 1'b1,
                         physical_address: {mem_rdata_i[51:30], va_q[29:0]},
                         leaf_level: LEAF_1G, window_fault: 1'b0};
            state_q <= S_OUT;
          end else if (leaf_2m) begin
            res_q   <= '{mapped: 1'b1,
                         physical_address: {mem_rdata_i[51:21], va_q[20:0]},
                         leaf_level: LEAF_2M, window_fault: 1'b0};
            state_q <= S_OUT;
          end else if (leaf_4k) begin
            res_q   <= '{mapped: 1'b1,
                         physical_address: {mem_rdata_i[51:12], va_q[11:0]},
                         leaf_level: LEAF_4K, window_fault: 1'b0};
            state_q <= S_OUT;
          end else if (!in_win) begin
            res_q   <= '{mapped: 1'b0, physical_address: '0,
                         leaf_level: LEAF_NONE, window_fault: 1'b1};
            state_q <= S_OUT;
          end else begin
            lvl_q <= lvl_q + 2'd1;
          end
        end
        S_OUT: begin
          if (res_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/page_table_walker_top.sv =====
// Top level of the page table walker: configuration registers, output register, assertions.
// Depends on ptw_pkg, ptw_mem, ptw_walk and page_table_walker_top_assert.svh.
//
// Usage: an input transfer with func_i = 0 stores entry_word_i at word entry_slot_i of the
// table memory (window table number times 512 plus entry) and yields no result; slots beyond
// the memory depth are dropped. An input transfer with func_i = 1 walks the four levels for
// virtual_address_i and yields one result transfer with mapped_o, physical_address_o,
// leaf_level_o and window_fault_o.
// A write does not hold the input channel. A translation holds it from the accepting cycle
// through one table level read per level visited (none when the root frame lies outside the
// window, up to four) until the result is handed to the output register. Each level's entry
// comes from the registered read port of the table memory before the next address is known.
// The output register lets the walker accept the next item while a result waits; if the
// receiver stalls, the following translation finishes and then holds the input channel until
// the output register frees up. Writes still go through during that time only if the walker
// is idle. Reset clears the root frame and window base registers and all control state; the
// table memory is not cleared and must be written before it is walked. Configuration
// registers are written over the APB-style port (root frame at 0x0, window base at 0x8); the
// user must write them only while idle, and the block itself does not enforce this.
`default_nettype none
`include "page_table_walker_top_assert.svh"

module page_table_walker_top import ptw_pkg::*; #(
  parameter int TableCount = PTW_TABLE_COUNT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               func_i,
  input  logic [VA_W-1:0]    virtual_address_i,
  input  logic [SLOT_W-1:0]  entry_slot_i,
  input  logic [ENTRY_W-1:0] entry_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               mapped_o,
  output logic [PA_W-1:0]    physical_address_o,
  output logic [1:0]         leaf_level_o,
  output logic               window_fault_o
);

  localparam int AddrW    = $clog2(TableCount) + IDX_W;
  localparam int MemDepth = TableCount * ENTRIES_PER_TABLE;

  logic [FRAME_W-1:0] root_frame_q;
  logic [FRAME_W-1:0] win_base_q;
  logic               reg_idx;
  logic               cfg_wr;

  logic               mem_we;
  logic [AddrW-1:0]   mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic               mem_re;
  logic [AddrW-1:0]   mem_raddr;
  logic [ENTRY_W-1:0] mem_rdata;

  logic               res_valid;
  logic               res_ready;
  ptw_res_t           res;

  logic               out_valid_q;
  ptw_res_t           out_res_q;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_frame_q <= '0;
      win_base_q   <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_ROOT_FRAME:  root_frame_q <= pwdata[FRAME_W-1:0];
        REG_WINDOW_BASE: win_base_q   <= pwdata[FRAME_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ROOT_FRAME:  prdata = 64'(root_frame_q);
      REG_WINDOW_BASE: prdata = 64'(win_base_q);
      default:         prdata = '0;
    endcase
  end

  ptw_walk #(
    .TableCount(TableCount)
  ) u_walk (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .func_i           (func_i),
    .virtual_address_i(virtual_address_i),
    .entry_slot_i     (entry_slot_i),
    .entry_word_i     (entry_word_i),
    .root_frame_i     (root_frame_q),
    .win_base_i       (win_base_q),
    .mem_we_o         (mem_we),
    .mem_waddr_o      (mem_waddr),
    .mem_wdata_o      (mem_wdata),
    .mem_re_o         (mem_re),
    .mem_raddr_o      (mem_raddr),
    .mem_rdata_i      (mem_rdata),
    .res_valid_o      (res_valid),
    .res_ready_i      (res_ready),
    .res_o            (res)
  );

  ptw_mem #(
    .Depth(MemDepth),
    .AddrW(AddrW),
    .DataW(ENTRY_W)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_res_q   <= '0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
      out_res_q   <= res;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign mapped_o           = out_res_q.mapped;
  assign physical_address_o = out_res_q.physical_address;
  assign leaf_level_o       = out_res_q.leaf_level;
  assign window_fault_o     = out_res_q.window_fault;

  `PTW_ASSERT(a_mem_port_excl, clk_i, rst_ni, !(mem_we && mem_re), "Table read and write in one cycle")
  `PTW_ASSERT_IMP(a_unmapped_zero, clk_i, rst_ni, out_valid_o && !mapped_o, physical_address_o == '0 && leaf_level_o == LEAF_NONE, "Unmapped result carries an address or level")
  `PTW_ASSERT_IMP(a_mapped_level, clk_i, rst_ni, out_valid_o, mapped_o == (leaf_level_o != LEAF_NONE), "Mapped flag disagrees with leaf level")
  `PTW_ASSERT_NEXT(a_walk_busy, clk_i, rst_ni, in_valid_i && in_ready_o && func_i == FUNC_XLATE, !in_ready_o, "Input taken while a walk is under way")

endmodule

`default_nettype wire

// ===== tb/sv/page_table_walker_top_test.sv =====
// Self-checking testbench for page_table_walker_top: table entry writes and four-level walks
// over valid/ready channels, predicted by a behavioral walk over a copy of the table memory.
// Depends on ptw_pkg and the page table walker RTL only.
`timescale 1ns / 100ps

module page_table_walker_top_test;
  import ptw_pkg::*;

  localparam int MEM_DEPTH = PTW_TABLE_COUNT * ENTRIES_PER_TABLE;
  localparam int LVL_PT    = 1;
  localparam int LVL_PD    = 2;
  localparam int LVL_PDPT  = 3;
  localparam int LVL_PML4  = 4;
  localparam int SETTLE_CYCLES = 8;
  localparam int RUN_LIMIT     = 500000;
  localparam int PHASE_ITEMS   = 130;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [3:0]          paddr = '0;
  logic [63:0]         pwdata = '0;
  logic [63:0]         prdata;
  logic                pready;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic                func_i = FUNC_WRITE;
  logic [VA_W-1:0]     virtual_address_i = '0;
  logic [SLOT_W-1:0]   entry_slot_i = '0;
  logic [ENTRY_W-1:0]  entry_word_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic                mapped_o;
  logic [PA_W-1:0]     physical_address_o;
  logic [1:0]          leaf_level_o;
  logic                window_fault_o;

  logic [ENTRY_W-1:0]  table_mem_q [MEM_DEPTH];
  bit                  slot_written_q [MEM_DEPTH];
  logic [FRAME_W-1:0]  root_frame_q = '0;
  logic [FRAME_W-1:0]  window_base_q = '0;
  ptw_res_t            pending_walks_q [$];

  bit          tx_idle_en = 1'b1;
  bit          rx_stall_en = 1'b1;
  int          stall_left = 0;
  int          items_sent = 0;
  int          writes_sent = 0;
  int          walks_sent = 0;
  int          mismatch_count = 0;
  int          leaf_tally [4] = '{0, 0, 0, 0};
  int          fault_tally = 0;
  int unsigned cycle_count = 0;

  page_table_walker_top i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .func_i             (func_i),
    .virtual_address_i  (virtual_address_i),
    .entry_slot_i       (entry_slot_i),
    .entry_word_i       (entry_word_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .mapped_o           (mapped_o),
    .physical_address_o (physical_address_o),
    .leaf_level_o       (leaf_level_o),
    .window_fault_o     (window_fault_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Walks the four levels over the local table copy. A read of a slot that was never written
  // stops the walk and reports that slot and its level, so the caller can build it first.
  function automatic ptw_res_t walk_tables(input logic [VA_W-1:0] va, output int missing_slot,
                                           output int missing_level);
    ptw_res_t           res;
    logic [FRAME_W-1:0] frame;
    logic [FRAME_W-1:0] offset;
    logic [ENTRY_W-1:0] ent;
    int                 lvl;
    int                 slot;
    bit                 done;
    res = '0;
    missing_slot = -1;
    missing_level = 0;
    frame = root_frame_q;
    done = 1'b0;
    for (lvl = LVL_PML4; lvl >= LVL_PT && !done; lvl--) begin
      offset = frame - window_base_q;
      if (frame < window_base_q || offset >= PTW_TABLE_COUNT) begin
        res.window_fault = 1'b1;
        done = 1'b1;
      end else begin
        slot = int'(offset) * ENTRIES_PER_TABLE + int'(va[12 + 9 * (lvl - 1) +: IDX_W]);
        if (!slot_written_q[slot]) begin
          missing_slot = slot;
          missing_level = lvl;
          done = 1'b1;
        end else begin
          ent = table_mem_q[slot];
          if (!ent[PRESENT_BIT]) begin
            done = 1'b1;
          end else if (lvl == LVL_PT) begin
            res.leaf_level = LEAF_4K;
            res.physical_address = {ent[51:12], va[11:0]};
            done = 1'b1;
          end else if (lvl != LVL_PML4 && ent[SIZE_BIT]) begin
            if (lvl == LVL_PDPT) begin
              res.leaf_level = LEAF_1G;
              res.physical_address = {ent[51:30], va[29:0]};
            end else begin
              res.leaf_level = LEAF_2M;
              res.physical_address = {ent[51:21], va[20:0]};
            end
            done = 1'b1;
          end else begin
            frame = ent[51:12];
          end
        end
      end
    end
    res.mapped = (res.leaf_level != LEAF_NONE);
    return res;
  endfunction

  // Mostly pointers into the window, some leaves, some absent entries, a few stray frames.
  function automatic logic [ENTRY_W-1:0] make_entry(input int level);
    logic [ENTRY_W-1:0] e;
    int                 pick;
    e = {$urandom, $urandom};
    pick = $urandom_range(0, 99);
    e[PRESENT_BIT] = (pick >= 6);
    if (pick >= 6 && pick < 12) begin
      e[51:12] = (pick < 9) ? window_base_q + 40'd16 + 40'($urandom_range(0, 4095))
                            : window_base_q - 40'd1 - 40'($urandom_range(0, 4095));
      if (level != LVL_PML4) e[SIZE_BIT] = 1'b0;
    end else if (pick >= 12 && (level == LVL_PML4 || (level != LVL_PT && pick < 72))) begin
      e[51:12] = window_base_q + 40'($urandom_range(0, PTW_TABLE_COUNT - 1));
      if (level != LVL_PML4) e[SIZE_BIT] = 1'b0;
    end else if (pick >= 12 && level != LVL_PT) begin
      e[SIZE_BIT] = 1'b1;
    end
    return e;
  endfunction

  function automatic logic [VA_W-1:0] pick_va();
    logic [VA_W-1:0] va;
    va = VA_W'({$urandom, $urandom});
    if ($urandom_range(0, 3) != 0) begin
      va[47:39] = 9'($urandom_range(0, 7));
      va[38:30] = 9'($urandom_range(0, 7));
      va[29:21] = 9'($urandom_range(0, 7));
      va[20:12] = 9'($urandom_range(0, 7));
    end
    return va;
  endfunction

  function automatic int pick_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (!tx_idle_en || pick < 55) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [SLOT_W-1:0] slot_of(input int tbl, input int idx);
    return SLOT_W'(tbl * ENTRIES_PER_TABLE + idx);
  endfunction

  function automatic logic [ENTRY_W-1:0] ptr_to(input logic [FRAME_W-1:0] delta);
    return {12'h000, window_base_q + delta, 12'h001};
  endfunction

  function automatic logic [VA_W-1:0] va_of(input logic [8:0] l4, input logic [8:0] l3,
                                            input logic [8:0] l2, input logic [8:0] l1,
                                            input logic [11:0] offset);
    return {l4, l3, l2, l1, offset};
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  task automatic send_item(input logic f, input logic [VA_W-1:0] va,
                           input logic [SLOT_W-1:0] slot, input logic [ENTRY_W-1:0] word);
    int gap;
    int missing_slot;
    int missing_level;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= f;
    virtual_address_i <= va;
    entry_slot_i <= slot;
    entry_word_i <= word;
    do @(posedge clk_i); while (!in_ready_o);
    if (f == FUNC_WRITE) begin
      table_mem_q[slot] = word;
      slot_written_q[slot] = 1'b1;
      writes_sent++;
    end else begin
      pending_walks_q.push_back(walk_tables(va, missing_slot, missing_level));
      walks_sent++;
    end
    items_sent++;
  endtask

  task automatic put_entry(input logic [SLOT_W-1:0] slot, input logic [ENTRY_W-1:0] word);
    send_item(FUNC_WRITE, VA_W'({$urandom, $urandom}), slot, word);
  endtask

  // Fills every entry the walk would read but that was never written, then translates.
  task automatic translate_built(input logic [VA_W-1:0] va);
    ptw_res_t res;
    int       missing_slot;
    int       missing_level;
    res = walk_tables(va, missing_slot, missing_level);
    while (missing_slot >= 0) begin
      put_entry(SLOT_W'(missing_slot), make_entry(missing_level));
      res = walk_tables(va, missing_slot, missing_level);
    end
    send_item(FUNC_XLATE, va, SLOT_W'($urandom), {$urandom, $urandom});
  endtask

  task automatic wait_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_walks_q.size() != 0);
  endtask

  task automatic write_reg(input logic idx, input logic [FRAME_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= {24'($urandom), value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_ROOT_FRAME) root_frame_q = value;
    else window_base_q = value;
    @(posedge clk_i);
  endtask

  task automatic set_walk_config(input logic [FRAME_W-1:0] root, input logic [FRAME_W-1:0] base);
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    write_reg(REG_WINDOW_BASE, base);
    write_reg(REG_ROOT_FRAME, root);
  endtask

  task automatic test_directed_walks();
    set_walk_config(40'h00_00AB_CDE0, 40'h00_00AB_CDE0);
    put_entry(slot_of(0, 0), 64'h0);
    translate_built('0);
    put_entry(slot_of(0, 511), ptr_to(40'd1) | (64'h1 << SIZE_BIT));
    put_entry(slot_of(1, 511), ptr_to(40'd2));
    put_entry(slot_of(2, 511), ptr_to(40'd3));
    put_entry(slot_of(3, 511), '1);
    translate_built('1);
    put_entry(slot_of(1, 0), '1);
    translate_built(va_of(9'd511, 9'd0, 9'h155, 9'h0AA, 12'h5A5));
    put_entry(slot_of(1, 1), ptr_to(40'd2));
    put_entry(slot_of(2, 0), 64'h000F_FFFF_FFFF_F081);
    translate_built(va_of(9'd511, 9'd1, 9'd0, 9'h1FF, 12'hFFF));
    put_entry(slot_of(2, 1), ptr_to(40'd3));
    put_entry(slot_of(3, 0), 64'hFFF0_0000_0000_0000);
    translate_built(va_of(9'd511, 9'd1, 9'd1, 9'd0, 12'h123));
    put_entry(slot_of(1, 2), 64'h0000_0000_0000_0080);
    translate_built(va_of(9'd511, 9'd2, 9'd0, 9'd0, 12'h000));
    put_entry(slot_of(0, 1), ptr_to(40'd16));
    translate_built(va_of(9'd1, 9'd0, 9'd0, 9'd0, 12'h000));
    put_entry(slot_of(0, 2), ptr_to('1));
    translate_built(va_of(9'd2, 9'd0, 9'd0, 9'd0, 12'h000));
    put_entry(13'h1FFF, {$urandom, $urandom});
  endtask

  task automatic test_root_outside_window();
    set_walk_config(40'h00_0001_2350, 40'h00_0001_2340);
    translate_built(pick_va());
    set_walk_config(40'h00_0001_233F, 40'h00_0001_2340);
    translate_built(pick_va());
    set_walk_config('1, '0);
    translate_built(pick_va());
  endtask

  task automatic test_random_walks();
    logic [FRAME_W-1:0] base;
    logic [FRAME_W-1:0] root;
    int                 ph;
    int                 stop_at;
    for (ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          base = '0;
          root = '0;
        end
        2: begin
          base = 40'hFF_FFFF_FFF0;
          root = '1;
        end
        4: begin
          base = '1;
          root = '1;
        end
        default: begin
          base = 40'({$urandom, $urandom});
          root = base + 40'($urandom_range(0, PTW_TABLE_COUNT - 1));
        end
      endcase
      set_walk_config(root, base);
      tx_idle_en = (ph != 3);
      rx_stall_en = (ph != 3);
      stop_at = items_sent + PHASE_ITEMS;
      while (items_sent < stop_at) begin
        if ($urandom_range(0, 99) < 2) begin
          wait_results();
        end else if ($urandom_range(0, 99) < 12) begin
          put_entry($urandom_range(0, 1) ? SLOT_W'($urandom)
                                         : slot_of($urandom_range(0, 15), $urandom_range(0, 7)),
                    make_entry($urandom_range(LVL_PT, LVL_PML4)));
        end else begin
          translate_built(pick_va());
        end
      end
    end
    tx_idle_en = 1'b1;
    rx_stall_en = 1'b1;
  endtask

  always @(posedge clk_i) begin : result_check
    ptw_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_walks_q.size() == 0) begin
        $error("result transfer with no translation pending");
        mismatch_count++;
      end else begin
        want = pending_walks_q.pop_front();
        check_field("mapped", 64'(want.mapped), 64'(mapped_o));
        check_field("physical_address", 64'(want.physical_address), 64'(physical_address_o));
        check_field("leaf_level", 64'(want.leaf_level), 64'(leaf_level_o));
        check_field("window_fault", 64'(want.window_fault), 64'(window_fault_o));
        leaf_tally[want.leaf_level]++;
        if (want.window_fault) fault_tally++;
      end
    end
    if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else if (rx_stall_en && $urandom_range(0, 99) < 25) begin
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 2);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  initial begin
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed_walks();
    test_root_outside_window();
    test_random_walks();
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Sent %0d entry writes and %0d translations across directed and random settings.",
             writes_sent, walks_sent);
    $display("Leaves: %0d of 4 KiB, %0d of 2 MiB, %0d of 1 GiB; %0d without a leaf (%0d faults).",
             leaf_tally[LEAF_4K], leaf_tally[LEAF_2M], leaf_tally[LEAF_1G],
             leaf_tally[LEAF_NONE], fault_tally);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== page_table_walker_top.f =====
+incdir+sv
sv/ptw_pkg.sv
sv/ptw_mem.sv
sv/ptw_walk.sv
sv/page_table_walker_top.sv
tb/sv/page_table_walker_top_test.sv
